// ===== hw/rtl/bsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants of the bitmap span fill block: item and result
// formats, register indexes, sequencer states and the byte span mask.
// ----------------------------------------------------------------------------
package bsf_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ROW_W      = 9;
  localparam int unsigned X_W        = 9;
  localparam int unsigned BYTE_W     = 6;
  localparam int unsigned RB_REG_W   = 7;
  localparam int unsigned HR_REG_W   = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_ROWS = 2'd1;

  // Register reset values
  localparam logic [RB_REG_W-1:0] ROW_BYTES_RST   = 7'd64;
  localparam logic [HR_REG_W-1:0] HEIGHT_ROWS_RST = 10'd512;

  localparam logic [7:0] FULL_BYTE = 8'hff;

  typedef enum logic {
    OP_FILL = 1'b0,
    OP_READ = 1'b1
  } bsf_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_FILL,
    ST_MERGE,
    ST_DONE
  } bsf_state_e;

  typedef struct packed {
    bsf_op_e           operation;
    logic [ROW_W-1:0]  row;
    logic [X_W-1:0]    x_start;
    logic [X_W-1:0]    x_end;
    logic [BYTE_W-1:0] byte_column;
  } bsf_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       rejected;
  } bsf_res_t;

  // Pixels lo..hi of a byte set, bit 7 is the leftmost pixel
  function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] left;
    logic [7:0] right;
    left  = FULL_BYTE >> lo;
    right = FULL_BYTE << (3'd7 - hi);
    return left & right;
  endfunction

endpackage

// ===== hw/rtl/bsf_intf.sv =====
// ----------------------------------------------------------------------------
// bsf_intf
// Valid/ready channels of the bitmap span fill block: item input, result
// output and configuration write.
// ----------------------------------------------------------------------------
interface bsf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [bsf_pkg::ROW_W-1:0]   row;
  logic [bsf_pkg::X_W-1:0]     x_start;
  logic [bsf_pkg::X_W-1:0]     x_end;
  logic [bsf_pkg::BYTE_W-1:0]  byte_column;

  modport source (output valid, operation, row, x_start, x_end, byte_column, input ready);
  modport sink   (input valid, operation, row, x_start, x_end, byte_column, output ready);
endinterface

interface bsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (output valid, read_byte, rejected, input ready);
  modport sink   (input valid, read_byte, rejected, output ready);
endinterface

interface bsf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bsf_pkg::CFG_IDX_W-1:0]     index;
  logic [bsf_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/bsf_store.sv =====
// ----------------------------------------------------------------------------
// bsf_store
// Single-port byte store of the bitmap, one access per cycle, registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
module bsf_store #(
  parameter int unsigned DEPTH = 32768
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [7:0]                                  wdata_i,
  output logic [7:0]                                  rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsf_ctrl
// Sequencer of the span fill: clears the store after reset, checks each item
// against the configured bitmap, and walks the bytes of a span through one
// shared address/mask unit (full bytes written, edge bytes read-modify-write).
// ----------------------------------------------------------------------------
module bsf_ctrl #(
  parameter int unsigned MAX_ROW_BYTES = 64,
  parameter int unsigned MAX_ROWS      = 512,
  localparam int unsigned DEPTH  = MAX_ROW_BYTES * MAX_ROWS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           item_valid_i,
  input  bsf_pkg::bsf_item_t             item_i,
  output logic                           item_ready_o,
  // configuration
  input  logic [bsf_pkg::RB_REG_W-1:0]   row_bytes_i,
  input  logic [bsf_pkg::HR_REG_W-1:0]   height_rows_i,
  // result toward the output register
  output logic                           res_valid_o,
  output bsf_pkg::bsf_res_t              res_o,
  input  logic                           res_ready_i,
  // store port
  output logic                           mem_we_o,
  output logic                           mem_re_o,
  output logic [ADDR_W-1:0]              mem_addr_o,
  output logic [7:0]                     mem_wdata_o,
  input  logic [7:0]                     mem_rdata_i
);

  localparam int unsigned RB_W   = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned HR_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned PROD_W = bsf_pkg::ROW_W + RB_W;

  bsf_pkg::bsf_state_e state_q, state_d;
  bsf_pkg::bsf_item_t  item_q, item_d;
  logic [ADDR_W-1:0]          clr_q, clr_d;
  logic [ADDR_W-1:0]          base_q, base_d;
  logic [bsf_pkg::BYTE_W-1:0] b_q, b_d;
  logic                       rej_q, rej_d;

  logic [RB_W-1:0]            rb_eff;
  logic [HR_W-1:0]            hr_eff;
  logic [PROD_W-1:0]          prod;
  logic [bsf_pkg::BYTE_W-1:0] b_first;
  logic [bsf_pkg::BYTE_W-1:0] b_last;
  logic [2:0]                 lo_bit;
  logic [2:0]                 hi_bit;
  logic [7:0]                 mask;
  logic [ADDR_W-1:0]          byte_addr;

  // Registers in use, out-of-range values clamped
  always_comb begin
    if (row_bytes_i == '0) begin
      rb_eff = RB_W'(1);
    end else if (32'(row_bytes_i) > MAX_ROW_BYTES) begin
      rb_eff = RB_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = RB_W'(row_bytes_i);
    end
    if (height_rows_i == '0) begin
      hr_eff = HR_W'(1);
    end else if (32'(height_rows_i) > MAX_ROWS) begin
      hr_eff = HR_W'(MAX_ROWS);
    end else begin
      hr_eff = HR_W'(height_rows_i);
    end
  end

  // Row base address
  assign prod = PROD_W'(item_q.row) * PROD_W'(rb_eff);

  // Shared byte unit: mask and address of the current span byte
  assign b_first   = item_q.x_start[bsf_pkg::X_W-1:3];
  assign b_last    = item_q.x_end[bsf_pkg::X_W-1:3];
  assign lo_bit    = (b_q == b_first) ? item_q.x_start[2:0] : 3'd0;
  assign hi_bit    = (b_q == b_last)  ? item_q.x_end[2:0]   : 3'd7;
  assign mask      = bsf_pkg::span_mask(lo_bit, hi_bit);
  assign byte_addr = base_q + ADDR_W'(b_q);

  // Next state and outputs
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    clr_d        = clr_q;
    base_d       = base_q;
    b_d          = b_q;
    rej_d        = rej_q;
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_addr_o   = byte_addr;
    mem_wdata_o  = bsf_pkg::FULL_BYTE;

    res_o.rejected  = rej_q;
    res_o.read_byte = (item_q.operation == bsf_pkg::OP_READ && !rej_q) ? mem_rdata_i : 8'h00;

    case (state_q)
      bsf_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = clr_q;
        mem_wdata_o = 8'h00;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = bsf_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      bsf_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = bsf_pkg::ST_CHECK;
        end
      end

      bsf_pkg::ST_CHECK: begin
        base_d = ADDR_W'(prod);
        b_d    = b_first;
        rej_d  = 1'b0;
        if (32'(item_q.row) >= 32'(hr_eff)) begin
          rej_d   = 1'b1;
          state_d = bsf_pkg::ST_DONE;
        end else if (item_q.operation == bsf_pkg::OP_READ) begin
          if (32'(item_q.byte_column) >= 32'(rb_eff)) begin
            rej_d   = 1'b1;
            state_d = bsf_pkg::ST_DONE;
          end else begin
            state_d = bsf_pkg::ST_READ;
          end
        end else if (item_q.x_start > item_q.x_end) begin
          // empty span: nothing written
          state_d = bsf_pkg::ST_DONE;
        end else if (32'(item_q.x_end) >= 32'(rb_eff) * 8) begin
          rej_d   = 1'b1;
          state_d = bsf_pkg::ST_DONE;
        end else begin
          state_d = bsf_pkg::ST_FILL;
        end
      end

      bsf_pkg::ST_READ: begin
        mem_re_o   = 1'b1;
        mem_addr_o = base_q + ADDR_W'(item_q.byte_column);
        state_d    = bsf_pkg::ST_DONE;
      end

      bsf_pkg::ST_FILL: begin
        if (mask == bsf_pkg::FULL_BYTE) begin
          // whole byte: plain write
          mem_we_o = 1'b1;
          if (b_q == b_last) begin
            state_d = bsf_pkg::ST_DONE;
          end else begin
            b_d = b_q + 1'b1;
          end
        end else begin
          // edge byte: fetch for merge
          mem_re_o = 1'b1;
          state_d  = bsf_pkg::ST_MERGE;
        end
      end

      bsf_pkg::ST_MERGE: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i | mask;
        if (b_q == b_last) begin
          state_d = bsf_pkg::ST_DONE;
        end else begin
          b_d     = b_q + 1'b1;
          state_d = bsf_pkg::ST_FILL;
        end
      end

      bsf_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = bsf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bsf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsf_pkg::ST_CLEAR;
      clr_q   <= '0;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rej_q   <= rej_d;
    end
  end

  // Item payload and walk position
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    base_q <= base_d;
    b_q    <= b_d;
  end

endmodule

// ===== hw/rtl/bitmap_span_fill.sv =====
// ----------------------------------------------------------------------------
// bitmap_span_fill
// One-bit-per-pixel bitmap with horizontal span fill and byte read.
// ----------------------------------------------------------------------------
// After reset the block sweeps the byte store to zero, one byte per cycle,
// over all MAX_ROW_BYTES * MAX_ROWS bytes (32768 at the defaults), and takes
// no item until the sweep ends; configuration writes are taken throughout.
// Items are handled one at a time by a sequencer around a single-port store.
// A rejected item or an empty span goes from IDLE through CHECK to DONE, a
// read through CHECK, READ and DONE. A fill writes each full byte of the span
// in FILL and takes each partly covered edge byte through FILL and MERGE,
// since an edge byte needs a read and a write on the same store port. A
// finished result sits in an output register, so the next item is taken while
// it waits.
// ----------------------------------------------------------------------------
module bitmap_span_fill #(
  parameter int unsigned MAX_ROW_BYTES = 64,
  parameter int unsigned MAX_ROWS      = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsf_in_if.sink    in_i,
  bsf_out_if.source out_o,
  bsf_cfg_if.sink   cfg_i
);

  localparam int unsigned DEPTH  = MAX_ROW_BYTES * MAX_ROWS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bsf_pkg::RB_REG_W-1:0] row_bytes_q;
  logic [bsf_pkg::HR_REG_W-1:0] height_rows_q;

  bsf_pkg::bsf_item_t item;
  bsf_pkg::bsf_res_t  res;
  bsf_pkg::bsf_res_t  out_res_q;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_q;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= bsf_pkg::ROW_BYTES_RST;
      height_rows_q <= bsf_pkg::HEIGHT_ROWS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bsf_pkg::REG_ROW_BYTES:   row_bytes_q   <= cfg_i.wdata[bsf_pkg::RB_REG_W-1:0];
        bsf_pkg::REG_HEIGHT_ROWS: height_rows_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Input item
  assign item.operation   = bsf_pkg::bsf_op_e'(in_i.operation);
  assign item.row         = in_i.row;
  assign item.x_start     = in_i.x_start;
  assign item.x_end       = in_i.x_end;
  assign item.byte_column = in_i.byte_column;

  bsf_ctrl #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_ROWS      (MAX_ROWS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (in_i.valid),
    .item_i        (item),
    .item_ready_o  (in_i.ready),
    .row_bytes_i   (row_bytes_q),
    .height_rows_i (height_rows_q),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready),
    .mem_we_o      (mem_we),
    .mem_re_o      (mem_re),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  bsf_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_byte = out_res_q.read_byte;
  assign out_o.rejected  = out_res_q.rejected;

endmodule

// ===== hw/rtl/bsf_checker.sv =====
// ----------------------------------------------------------------------------
// bsf_checker
// Port-level checks of the bitmap span fill block, bound to the top level.
// ----------------------------------------------------------------------------
module bsf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_read_byte_i,
  input logic       out_rejected_i
);

  // A result waiting on the sink stays up and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_read_byte_i)
                                    && $stable(out_rejected_i))
    else $error("stalled result dropped or changed");

  // One item at a time: after a transfer in, input is not ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // Rejected items never return stored data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rejected_i |-> out_read_byte_i == 8'h00)
    else $error("rejected result carries a nonzero byte");

  // Right after reset release, while the store clear runs, input ready and output valid are low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i && !out_valid_i)
    else $error("block busy state wrong after reset release");

endmodule

bind bitmap_span_fill bsf_checker u_bsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_read_byte_i (out_o.read_byte),
  .out_rejected_i  (out_o.rejected)
);

// ===== tb/tb_bitmap_span_fill.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_span_fill
// Self-checking bench for the bitmap span fill block. A queue of span and
// read items feeds a clocked driver; a clocked monitor predicts each result
// from a private copy of the bitmap and checks the returned transfers in
// order. Runs a directed set, then random phases over several geometries
// and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_bitmap_span_fill;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned MAX_RB        = 64;
  localparam int unsigned MAX_HR        = 512;
  localparam int unsigned STORE_DEPTH   = MAX_RB * MAX_HR;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned PHASE_ITEMS   = 170;
  localparam int unsigned REPORT_LIMIT  = 10;

  // indexes the block has no register behind
  localparam logic [bsf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [bsf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic clk_i;
  logic rst_ni;

  bsf_in_if  span_if ();
  bsf_out_if res_if ();
  bsf_cfg_if cfg_if ();

  bitmap_span_fill dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (span_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Bitmap copy and register shadows
  logic [7:0]                   bitmap_copy [STORE_DEPTH];
  logic [bsf_pkg::RB_REG_W-1:0] row_bytes_reg;
  logic [bsf_pkg::HR_REG_W-1:0] height_reg;

  bsf_pkg::bsf_item_t span_items [$];
  bsf_pkg::bsf_res_t  pending_results [$];
  logic               span_taken;
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        fail_cnt;
  int unsigned        cycle_cnt;

  // Clock
  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic int unsigned active_row_bytes();
    if (row_bytes_reg == '0) return 1;
    if (row_bytes_reg > MAX_RB) return MAX_RB;
    return 32'(row_bytes_reg);
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == '0) return 1;
    if (height_reg > MAX_HR) return MAX_HR;
    return 32'(height_reg);
  endfunction

  // Applies one item to the bitmap copy and returns the result it yields
  function automatic bsf_pkg::bsf_res_t predict_bitmap_result(input bsf_pkg::bsf_item_t it);
    int unsigned       rb;
    int unsigned       base;
    int unsigned       b_first;
    int unsigned       b_last;
    logic [2:0]        lo;
    logic [2:0]        hi;
    logic [7:0]        bits;
    bsf_pkg::bsf_res_t res;
    rb   = active_row_bytes();
    base = 32'(it.row) * rb;
    res  = '0;
    if (it.row >= active_height()) begin
      res.rejected = 1'b1;
    end else if (it.operation == bsf_pkg::OP_READ) begin
      if (it.byte_column >= rb) res.rejected = 1'b1;
      else res.read_byte = bitmap_copy[base + 32'(it.byte_column)];
    end else if (it.x_start <= it.x_end) begin
      if (it.x_end >= rb * 8) begin
        res.rejected = 1'b1;
      end else begin
        b_first = 32'(it.x_start) >> 3;
        b_last  = 32'(it.x_end) >> 3;
        for (int unsigned b = b_first; b <= b_last; b++) begin
          lo   = (b == b_first) ? it.x_start[2:0] : 3'd0;
          hi   = (b == b_last) ? it.x_end[2:0] : 3'd7;
          bits = (8'hff >> lo) & ~(8'h7f >> hi);
          bitmap_copy[base + b] = bitmap_copy[base + b] | bits;
        end
      end
    end
    return res;
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT)
      $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  // Item driver: new item at the falling edge once the last one transferred
  always @(negedge clk_i) begin : drive_items
    bsf_pkg::bsf_item_t it;
    if (!span_if.valid || span_taken) begin
      if (span_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = span_items.pop_front();
        span_if.valid       <= 1'b1;
        span_if.operation   <= it.operation;
        span_if.row         <= it.row;
        span_if.x_start     <= it.x_start;
        span_if.x_end       <= it.x_end;
        span_if.byte_column <= it.byte_column;
      end else begin
        span_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check result transfers, predict on item transfers
  always @(posedge clk_i) begin : watch
    bsf_pkg::bsf_item_t seen;
    bsf_pkg::bsf_res_t  want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing pending", 0,
                        int'({res_if.read_byte, res_if.rejected}));
        end else begin
          want = pending_results.pop_front();
          if (res_if.read_byte !== want.read_byte)
            note_mismatch("read_byte", int'(want.read_byte), int'(res_if.read_byte));
          if (res_if.rejected !== want.rejected)
            note_mismatch("rejected", int'(want.rejected), int'(res_if.rejected));
        end
      end
      if (span_if.valid && span_if.ready) begin
        seen.operation   = bsf_pkg::bsf_op_e'(span_if.operation);
        seen.row         = span_if.row;
        seen.x_start     = span_if.x_start;
        seen.x_end       = span_if.x_end;
        seen.byte_column = span_if.byte_column;
        pending_results.push_back(predict_bitmap_result(seen));
      end
    end
    span_taken <= rst_ni && span_if.valid && span_if.ready;
  end

  // Register write over the configuration channel
  task automatic write_reg(input logic [bsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == bsf_pkg::REG_ROW_BYTES) row_bytes_reg = val[bsf_pkg::RB_REG_W-1:0];
    else if (idx == bsf_pkg::REG_HEIGHT_ROWS) height_reg = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Everything sent, every result back, then a quiet stretch
  task automatic wait_idle();
    do @(negedge clk_i);
    while (span_items.size() != 0 || span_if.valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [bsf_pkg::CFG_DATA_W-1:0] rb,
                              input logic [bsf_pkg::CFG_DATA_W-1:0] hr);
    wait_idle();
    write_reg(bsf_pkg::REG_ROW_BYTES, rb);
    write_reg(bsf_pkg::REG_HEIGHT_ROWS, hr);
    write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
              bsf_pkg::CFG_DATA_W'($urandom));
  endtask

  task automatic queue_fill(input int unsigned row, input int unsigned xs, input int unsigned xe);
    bsf_pkg::bsf_item_t it;
    it.operation   = bsf_pkg::OP_FILL;
    it.row         = bsf_pkg::ROW_W'(row);
    it.x_start     = bsf_pkg::X_W'(xs);
    it.x_end       = bsf_pkg::X_W'(xe);
    it.byte_column = bsf_pkg::BYTE_W'($urandom);
    span_items.push_back(it);
  endtask

  task automatic queue_read(input int unsigned row, input int unsigned col);
    bsf_pkg::bsf_item_t it;
    it.operation   = bsf_pkg::OP_READ;
    it.row         = bsf_pkg::ROW_W'(row);
    it.x_start     = bsf_pkg::X_W'($urandom);
    it.x_end       = bsf_pkg::X_W'($urandom);
    it.byte_column = bsf_pkg::BYTE_W'(col);
    span_items.push_back(it);
  endtask

  // Mostly in-range spans and reads on a few hot rows, some out-of-range noise
  function automatic bsf_pkg::bsf_item_t random_item();
    bsf_pkg::bsf_item_t it;
    int unsigned        rb;
    int unsigned        hr;
    int unsigned        width;
    int unsigned        pick;
    int unsigned        xs;
    int unsigned        xe;
    rb    = active_row_bytes();
    hr    = active_height();
    width = rb * 8;
    it.operation   = ($urandom_range(99) < 55) ? bsf_pkg::OP_FILL : bsf_pkg::OP_READ;
    it.x_start     = bsf_pkg::X_W'($urandom);
    it.x_end       = bsf_pkg::X_W'($urandom);
    it.byte_column = bsf_pkg::BYTE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) it.row = bsf_pkg::ROW_W'($urandom_range((hr < 8) ? hr - 1 : 7));
    else if (pick < 85) it.row = bsf_pkg::ROW_W'($urandom_range(hr - 1));
    else it.row = bsf_pkg::ROW_W'($urandom_range(MAX_HR - 1));
    if (it.operation == bsf_pkg::OP_FILL) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        xs = $urandom_range(width - 1);
        xe = xs + $urandom_range(15);
        if (xe > width - 1) xe = width - 1;
        it.x_start = bsf_pkg::X_W'(xs);
        it.x_end   = bsf_pkg::X_W'(xe);
      end else if (pick < 80) begin
        xs = $urandom_range(width - 1);
        xe = $urandom_range(width - 1, xs);
        it.x_start = bsf_pkg::X_W'(xs);
        it.x_end   = bsf_pkg::X_W'(xe);
      end else if (pick < 90) begin
        // empty span, start past end
        xs = $urandom_range(511, 1);
        xe = $urandom_range(xs - 1);
        it.x_start = bsf_pkg::X_W'(xs);
        it.x_end   = bsf_pkg::X_W'(xe);
      end else if (width < 512) begin
        // span running past the row width
        xe = $urandom_range(511, width);
        xs = $urandom_range(xe);
        it.x_start = bsf_pkg::X_W'(xs);
        it.x_end   = bsf_pkg::X_W'(xe);
      end
    end else if ($urandom_range(99) < 85) begin
      it.byte_column = bsf_pkg::BYTE_W'($urandom_range(rb - 1));
    end
    return it;
  endfunction

  task automatic run_phase(input logic [bsf_pkg::CFG_DATA_W-1:0] rb,
                           input logic [bsf_pkg::CFG_DATA_W-1:0] hr,
                           input int unsigned send_pct, input int unsigned recv_pct);
    set_geometry(rb, hr);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (PHASE_ITEMS) span_items.push_back(random_item());
  endtask

  // Timeout
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Stimulus sequence
  initial begin
    span_if.valid       = 1'b0;
    span_if.operation   = bsf_pkg::OP_FILL;
    span_if.row         = '0;
    span_if.x_start     = '0;
    span_if.x_end       = '0;
    span_if.byte_column = '0;
    res_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = bsf_pkg::REG_ROW_BYTES;
    cfg_if.wdata        = '0;
    span_taken          = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    fail_cnt            = 0;
    cycle_cnt           = 0;
    row_bytes_reg       = bsf_pkg::ROW_BYTES_RST;
    height_reg          = bsf_pkg::HEIGHT_ROWS_RST;
    foreach (bitmap_copy[i]) bitmap_copy[i] = 8'h00;

    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset geometry, full row, byte edges, single pixels
    queue_fill(0, 0, 511);
    queue_read(0, 0);
    queue_read(0, 63);
    queue_fill(1, 0, 0);
    queue_fill(1, 7, 7);
    queue_read(1, 0);
    queue_fill(2, 3, 12);
    queue_read(2, 0);
    queue_read(2, 1);
    queue_fill(3, 2, 5);
    queue_read(3, 0);
    queue_fill(4, 10, 9);
    queue_read(4, 1);
    queue_fill(511, 504, 511);
    queue_read(511, 63);
    queue_read(511, 0);
    queue_fill(5, 511, 0);

    // Directed: small geometry, rejects and stale layout after a width change
    set_geometry(3, 4);
    queue_fill(4, 0, 0);
    queue_read(4, 0);
    queue_fill(0, 0, 24);
    queue_fill(3, 0, 23);
    queue_read(3, 2);
    queue_fill(2, 30, 20);
    queue_fill(9, 30, 20);
    queue_read(0, 3);
    queue_read(1, 0);

    // Random phases over geometries and idle patterns
    run_phase(64, 512, 0, 0);
    run_phase(1, 1, 69, 0);
    run_phase(0, 0, 0, 69);
    run_phase(127, 1023, 34, 34);
    run_phase(13, 40, 0, 0);
    run_phase(64, 512, 69, 0);
    run_phase(7, 200, 0, 69);
    run_phase(bsf_pkg::CFG_DATA_W'($urandom_range(127)),
              bsf_pkg::CFG_DATA_W'($urandom_range(1023)), 34, 34);

    wait_idle();
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
